// File: design/grid_bicubic_interpolator_macros.svh
// ----------------------------------------------------------------------------
// grid_bicubic_interpolator_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef GRID_BICUBIC_INTERPOLATOR_MACROS_SVH
`define GRID_BICUBIC_INTERPOLATOR_MACROS_SVH

// Checked only outside reset.
`define GBI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GBI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/gbi_pkg.sv
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared constants and types of the bicubic grid interpolator.
// ----------------------------------------------------------------------------
package gbi_pkg;

  localparam int MAX_CELLS_X_DEF = 128;
  localparam int MAX_CELLS_Y_DEF = 128;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int CELL_W    = 16;   // Q0.16 cell value
  localparam int CFG_W     = 8;    // size register width
  localparam int QUERY_W   = 17;   // signed coordinate
  localparam int POS_W     = 18;   // signed neighbor index, one bit over QUERY_W
  localparam int WEIGHT_W  = 18;   // signed Q.16 kernel weight
  localparam int PROD_W    = 2 * WEIGHT_W;
  localparam int ACC_W     = 54;   // Q.48 sum of sixteen products
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] CELLS_RESET = 8'd128;

  localparam logic REG_CELLS_X = 1'b0;
  localparam logic REG_CELLS_Y = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [3:0][WEIGHT_W-1:0] weight_set_t;

  typedef struct packed {
    logic        valid;
    logic        tag;     // 0: x axis, 1: y axis
    weight_set_t w;
  } wres_t;

  // command word: query flag, write data, 4 column and 4 row indices, 8 weights
  function automatic int cmd_width(input int xw, input int yw);
    return 1 + CELL_W + 4 * xw + 4 * yw + 8 * WEIGHT_W;
  endfunction

endpackage

// File: design/gbi_ram.sv
// ----------------------------------------------------------------------------
// gbi_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module gbi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/gbi_fifo.sv
// ----------------------------------------------------------------------------
// gbi_fifo
// Small show-ahead register queue.
// ----------------------------------------------------------------------------
module gbi_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: design/gbi_weight.sv
// ----------------------------------------------------------------------------
// gbi_weight
// Three-stage cubic-convolution weight unit (a = -1) for one axis fraction.
// ----------------------------------------------------------------------------
module gbi_weight #(
  parameter int FRAC_BITS = gbi_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_tag,
  input  logic [FRAC_BITS-1:0] in_t,
  output gbi_pkg::wres_t       res
);

  localparam int F    = FRAC_BITS;
  localparam int SQ_W = 2 * F + 2;
  localparam int CU_W = 3 * F + 3;
  localparam int EW   = (3 * F + 4 > 20) ? 3 * F + 4 : 20;
  localparam int SH   = 3 * F - 16;
  localparam int RSH  = (SH > 0) ? SH : 0;
  localparam int LSH  = (SH > 0) ? 0 : -SH;
  localparam int RND_POS = (RSH > 0) ? RSH - 1 : 0;
  localparam logic signed [EW-1:0] RND = (RSH > 0) ? (EW'(1) << RND_POS) : '0;
  localparam logic signed [EW-1:0] ONE = EW'(1) << (3 * F);

  // stage 1: squares
  logic            v1, tag1;
  logic [F-1:0]    t1;
  logic [F:0]      u1;
  logic [SQ_W-1:0] t2, u2;
  // stage 2: cubes and cross terms
  logic            v2, tag2;
  logic [SQ_W-1:0] t2d, u2d;
  logic [CU_W-1:0] t3, u3, tu2, ut2;

  logic [F:0]             u_in;
  logic signed [EW-1:0]   e0, e1, e2, e3;
  gbi_pkg::weight_set_t   w_next;

  function automatic logic [gbi_pkg::WEIGHT_W-1:0] WEIGHT_SLICE(
      input logic signed [EW-1:0] e);
    logic signed [EW-1:0] q;
    q = (e >>> RSH) <<< LSH;
    return q[gbi_pkg::WEIGHT_W-1:0];
  endfunction

  assign u_in = {1'b1, {F{1'b0}}} - {1'b0, in_t};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      res.valid <= v2;
    end
    res.tag <= tag2;
    res.w   <= w_next;
  end

  always_ff @(posedge clk) begin
    tag1    <= in_tag;
    t1      <= in_t;
    u1      <= u_in;
    t2      <= SQ_W'(in_t) * SQ_W'(in_t);
    u2      <= SQ_W'(u_in) * SQ_W'(u_in);
    tag2    <= tag1;
    t2d     <= t2;
    u2d     <= u2;
    t3      <= CU_W'(t2) * CU_W'(t1);
    u3      <= CU_W'(u2) * CU_W'(u1);
    tu2     <= CU_W'(u2) * CU_W'(t1);
    ut2     <= CU_W'(t2) * CU_W'(u1);
  end

  // weights scaled by S^3, rounding bias folded in, then aligned to Q.16
  always_comb begin
    e0 = RND - EW'(tu2);
    e1 = EW'(t3) - (EW'(t2d) << (F + 1)) + ONE + RND;
    e2 = EW'(u3) - (EW'(u2d) << (F + 1)) + ONE + RND;
    e3 = RND - EW'(ut2);
    w_next[0] = WEIGHT_SLICE(e0);
    w_next[1] = WEIGHT_SLICE(e1);
    w_next[2] = WEIGHT_SLICE(e2);
    w_next[3] = WEIGHT_SLICE(e3);
  end

endmodule

// File: design/gbi_front.sv
// ----------------------------------------------------------------------------
// gbi_front
// Takes items, forwards cell writes, turns queries into clamped neighbor
// indices and kernel weights, and queues the resulting commands.
// ----------------------------------------------------------------------------
module gbi_front #(
  parameter int MAX_CELLS_X = gbi_pkg::MAX_CELLS_X_DEF,
  parameter int MAX_CELLS_Y = gbi_pkg::MAX_CELLS_Y_DEF,
  parameter int FRAC_BITS   = gbi_pkg::FRAC_BITS_DEF,
  localparam int XW    = $clog2(MAX_CELLS_X),
  localparam int YW    = $clog2(MAX_CELLS_Y),
  localparam int CMD_W = gbi_pkg::cmd_width(XW, YW)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                func,
  input  logic [6:0]                          write_x,
  input  logic [6:0]                          write_y,
  input  logic [gbi_pkg::CELL_W-1:0]          write_value,
  input  logic signed [gbi_pkg::QUERY_W-1:0]  query_x,
  input  logic signed [gbi_pkg::QUERY_W-1:0]  query_y,
  input  logic [gbi_pkg::CFG_W-1:0]           cells_x,
  input  logic [gbi_pkg::CFG_W-1:0]           cells_y,
  input  logic                                clearing,
  output logic                                cmd_push,
  output logic [CMD_W-1:0]                    cmd_data,
  input  logic                                cmd_full
);

  localparam int PW = gbi_pkg::POS_W;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_ISSUE_Y = 2'd1;
  localparam logic [1:0] ST_WAIT    = 2'd2;
  localparam logic [1:0] ST_PUSH    = 2'd3;

  logic [1:0]              state, state_next;
  logic signed [PW-1:0]    fx, fy;
  logic [FRAC_BITS-1:0]    t_y;
  gbi_pkg::weight_set_t    wx, wy;
  gbi_pkg::wres_t          wres;

  logic                    accept;
  logic                    is_query;
  logic                    write_ok;
  logic                    w_in_valid;
  logic                    w_in_tag;
  logic [FRAC_BITS-1:0]    w_in_t;
  logic [PW-1:0]           nx, ny;
  logic [3:0][XW-1:0]      q_ix, c_ix;
  logic [3:0][YW-1:0]      q_iy, c_iy;

  function automatic logic [PW-1:0] eff_size(input logic [gbi_pkg::CFG_W-1:0] r,
                                             input int maxv);
    if (r == '0) begin
      return PW'(1);
    end else if (PW'(r) > PW'(maxv)) begin
      return PW'(maxv);
    end
    return PW'(r);
  endfunction

  function automatic logic [PW-1:0] clamp_pos(input logic signed [PW-1:0] p,
                                              input logic [PW-1:0] n);
    if (p < 0) begin
      return '0;
    end else if ($unsigned(p) >= n) begin
      return n - PW'(1);
    end
    return $unsigned(p);
  endfunction

  assign full     = clearing || (state != ST_IDLE) || cmd_full;
  assign accept   = push && !full;
  assign is_query = (func == gbi_pkg::FUNC_QUERY);
  assign write_ok = (32'(write_x) < MAX_CELLS_X) && (32'(write_y) < MAX_CELLS_Y);

  // x fraction goes in on the accept cycle, y fraction on the next
  assign w_in_valid = (accept && is_query) || (state == ST_ISSUE_Y);
  assign w_in_tag   = (state == ST_ISSUE_Y);
  assign w_in_t     = (state == ST_ISSUE_Y) ? t_y : query_x[FRAC_BITS-1:0];

  gbi_weight #(
    .FRAC_BITS (FRAC_BITS)
  ) u_weight (
    .clk      (clk),
    .rst      (rst),
    .in_valid (w_in_valid),
    .in_tag   (w_in_tag),
    .in_t     (w_in_t),
    .res      (wres)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_next = ST_ISSUE_Y;
        end
      end
      ST_ISSUE_Y: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (wres.valid && wres.tag) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!cmd_full) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      fx  <= PW'(query_x >>> FRAC_BITS);
      fy  <= PW'(query_y >>> FRAC_BITS);
      t_y <= query_y[FRAC_BITS-1:0];
    end
    if (wres.valid && !wres.tag) begin
      wx <= wres.w;
    end
    if (wres.valid && wres.tag) begin
      wy <= wres.w;
    end
  end

  // neighbors floor-1 .. floor+2, clamped into the configured size
  always_comb begin
    nx = eff_size(cells_x, MAX_CELLS_X);
    ny = eff_size(cells_y, MAX_CELLS_Y);
    for (int i = 0; i < 4; i++) begin
      q_ix[i] = XW'(clamp_pos(fx + PW'(i - 1), nx));
      q_iy[i] = YW'(clamp_pos(fy + PW'(i - 1), ny));
    end
    c_ix    = '0;
    c_iy    = '0;
    c_ix[0] = XW'(write_x);
    c_iy[0] = YW'(write_y);
  end

  always_comb begin
    if (state == ST_PUSH) begin
      cmd_push = !cmd_full;
      cmd_data = {gbi_pkg::FUNC_QUERY, {gbi_pkg::CELL_W{1'b0}}, q_ix, q_iy, wx, wy};
    end else begin
      // out-of-store writes are taken and dropped
      cmd_push = accept && !is_query && write_ok;
      cmd_data = {gbi_pkg::FUNC_WRITE, write_value, c_ix, c_iy, wx, wy};
    end
  end

endmodule

// File: design/gbi_back.sv
// ----------------------------------------------------------------------------
// gbi_back
// Owns the grid RAM: clears it after reset, applies cell writes and runs
// the sixteen-read multiply-accumulate of each query.
// ----------------------------------------------------------------------------
module gbi_back #(
  parameter int MAX_CELLS_X = gbi_pkg::MAX_CELLS_X_DEF,
  parameter int MAX_CELLS_Y = gbi_pkg::MAX_CELLS_Y_DEF,
  localparam int XW    = $clog2(MAX_CELLS_X),
  localparam int YW    = $clog2(MAX_CELLS_Y),
  localparam int CMD_W = gbi_pkg::cmd_width(XW, YW)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_empty,
  input  logic [CMD_W-1:0]           cmd_data,
  output logic                       cmd_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output logic [gbi_pkg::CELL_W-1:0] res_data,
  output logic                       clearing
);

  localparam int DEPTH  = MAX_CELLS_X * MAX_CELLS_Y;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = gbi_pkg::CELL_W;
  localparam int WW     = gbi_pkg::WEIGHT_W;
  localparam int AW     = gbi_pkg::ACC_W;

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_READ  = 2'd2;
  localparam logic [1:0] B_DRAIN = 2'd3;

  logic                  c_query;
  logic [CW-1:0]         c_wdata;
  logic [3:0][XW-1:0]    c_ix;
  logic [3:0][YW-1:0]    c_iy;
  gbi_pkg::weight_set_t  c_wx, c_wy;

  logic [1:0]            state;
  logic [ADDR_W-1:0]     clr_addr;
  logic [3:0]            rd_cnt;
  logic [3:0][XW-1:0]    q_ix;
  logic [3:0][YW-1:0]    q_iy;
  gbi_pkg::weight_set_t  q_wx, q_wy;

  logic [1:0]            sel_i, sel_j;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [CW-1:0]         ram_wdata, ram_rdata;

  logic                          s1_v, s1_last, s2_v, s2_last, s3_v, s3_last, done;
  logic signed [gbi_pkg::PROD_W-1:0] prod;
  logic [WW+CW-1:0]              lo;
  logic signed [WW+CW:0]         hi;
  logic signed [AW-1:0]          term;
  logic signed [AW-1:0]          acc;
  logic [AW-1:0]                 rounded;

  assign {c_query, c_wdata, c_ix, c_iy, c_wx, c_wy} = cmd_data;

  assign clearing = (state == B_CLEAR);
  assign sel_i    = rd_cnt[1:0];
  assign sel_j    = rd_cnt[3:2];
  assign rd_addr  = ADDR_W'(q_iy[sel_j]) * ADDR_W'(MAX_CELLS_X) + ADDR_W'(q_ix[sel_i]);
  assign wr_addr  = ADDR_W'(c_iy[0]) * ADDR_W'(MAX_CELLS_X) + ADDR_W'(c_ix[0]);

  // a query starts only with room for its result, so its push never stalls
  assign cmd_pop = (state == B_IDLE) && !cmd_empty &&
                   ((c_query == gbi_pkg::FUNC_WRITE) || !res_full);

  always_comb begin
    ram_we    = clearing || (cmd_pop && (c_query == gbi_pkg::FUNC_WRITE));
    ram_wdata = clearing ? '0 : c_wdata;
    priority if (clearing) begin
      ram_addr = clr_addr;
    end else if (state == B_READ) begin
      ram_addr = rd_addr;
    end else begin
      ram_addr = wr_addr;
    end
  end

  gbi_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      rd_cnt   <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_v <= (state == B_READ);
      s2_v <= s1_v;
      s3_v <= s2_v;
      done <= s3_v && s3_last;
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          rd_cnt <= '0;
          if (cmd_pop && (c_query == gbi_pkg::FUNC_QUERY)) begin
            state <= B_READ;
          end
        end
        B_READ: begin
          rd_cnt <= rd_cnt + 1'b1;
          if (&rd_cnt) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (done) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // read issue -> weight product | cell products | term | accumulate
  always_ff @(posedge clk) begin
    if (cmd_pop && (c_query == gbi_pkg::FUNC_QUERY)) begin
      q_ix <= c_ix;
      q_iy <= c_iy;
      q_wx <= c_wx;
      q_wy <= c_wy;
      acc  <= '0;
    end else if (s3_v) begin
      acc <= acc + term;
    end
    prod    <= $signed(q_wx[sel_i]) * $signed(q_wy[sel_j]);
    s1_last <= &rd_cnt;
    lo      <= prod[WW-1:0] * ram_rdata;
    hi      <= $signed(prod[2*WW-1:WW]) * $signed({1'b0, ram_rdata});
    s2_last <= s1_last;
    term    <= (AW'(hi) <<< WW) + AW'(lo);
    s3_last <= s2_last;
  end

  // Q.48 sum to Q0.16, half up, saturated to [0, 1]
  always_comb begin
    rounded = acc + (AW'(1) << 31);
    priority if (acc[AW-1]) begin
      res_data = '0;
    end else if (|rounded[AW-1:32+CW]) begin
      res_data = '1;
    end else begin
      res_data = rounded[32+CW-1:32];
    end
  end

  assign res_push = done;

endmodule

// File: design/grid_bicubic_interpolator.sv
// ----------------------------------------------------------------------------
// grid_bicubic_interpolator: a write is taken into the command queue and lands in the grid
// when the back end pops it. A query passes the weight unit, the command queue and the back
// end; its rate is set by sixteen reads of the single-port grid RAM plus the multiply-accumulate
// drain, and new items are taken while the back end still works on an earlier query.
// rst: sizes return to 128, then a clear pass zeroes all MAX_CELLS_X*MAX_CELLS_Y cells.
// ----------------------------------------------------------------------------
module grid_bicubic_interpolator #(
  parameter int MAX_CELLS_X = gbi_pkg::MAX_CELLS_X_DEF,
  parameter int MAX_CELLS_Y = gbi_pkg::MAX_CELLS_Y_DEF,
  parameter int FRAC_BITS   = gbi_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                func,
  input  logic [6:0]                          write_x,
  input  logic [6:0]                          write_y,
  input  logic [gbi_pkg::CELL_W-1:0]          write_value,
  input  logic signed [gbi_pkg::QUERY_W-1:0]  query_x,
  input  logic signed [gbi_pkg::QUERY_W-1:0]  query_y,
  output logic                                empty,
  input  logic                                pop,
  output logic [gbi_pkg::CELL_W-1:0]          smoothed_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gbi_pkg::APB_AW-1:0]          paddr,
  input  logic [gbi_pkg::APB_DW-1:0]          pwdata,
  output logic [gbi_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int XW    = $clog2(MAX_CELLS_X);
  localparam int YW    = $clog2(MAX_CELLS_Y);
  localparam int CMD_W = gbi_pkg::cmd_width(XW, YW);
  localparam int CFW   = gbi_pkg::CFG_W;

  logic [CFW-1:0]                 cells_x, cells_y;
  logic                           cfg_wr;
  logic                           clearing;
  logic                           cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0]               cmd_in, cmd_head;
  logic                           res_push, res_full;
  logic [gbi_pkg::CELL_W-1:0]     res_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= gbi_pkg::CELLS_RESET;
      cells_y <= gbi_pkg::CELLS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == gbi_pkg::REG_CELLS_X) begin
        cells_x <= pwdata[CFW-1:0];
      end else begin
        cells_y <= pwdata[CFW-1:0];
      end
    end
  end

  assign prdata = {{(gbi_pkg::APB_DW - CFW){1'b0}},
                   (paddr[2] == gbi_pkg::REG_CELLS_Y) ? cells_y : cells_x};

  gbi_front #(
    .MAX_CELLS_X (MAX_CELLS_X),
    .MAX_CELLS_Y (MAX_CELLS_Y),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .write_x     (write_x),
    .write_y     (write_y),
    .write_value (write_value),
    .query_x     (query_x),
    .query_y     (query_y),
    .cells_x     (cells_x),
    .cells_y     (cells_y),
    .clearing    (clearing),
    .cmd_push    (cmd_push),
    .cmd_data    (cmd_in),
    .cmd_full    (cmd_full)
  );

  gbi_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (gbi_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .head      (cmd_head)
  );

  gbi_back #(
    .MAX_CELLS_X (MAX_CELLS_X),
    .MAX_CELLS_Y (MAX_CELLS_Y)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .clearing  (clearing)
  );

  gbi_fifo #(
    .WIDTH (gbi_pkg::CELL_W),
    .DEPTH (gbi_pkg::RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (pop),
    .empty     (empty),
    .head      (smoothed_value)
  );

endmodule

// File: design/gbi_checker.sv
// ----------------------------------------------------------------------------
// gbi_checker
// Port-level checks of the bicubic grid interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_bicubic_interpolator_macros.svh"

module gbi_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic [gbi_pkg::CELL_W-1:0]          smoothed_value,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [gbi_pkg::APB_AW-1:0]          paddr,
  input logic [gbi_pkg::APB_DW-1:0]          pwdata,
  input logic [gbi_pkg::APB_DW-1:0]          prdata
);

  // reset flushes the result queue
  `GBI_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result queue not empty after reset")

  // grid clear pass holds off input right after reset
  `GBI_ASSERT(a_clear_blocks, clk, rst, $fell(rst) |-> full, "input open during grid clear")

  // a size register reads back what was written
  `GBI_ASSERT(a_cfg_readback, clk, rst, (psel && penable && pwrite) |=> (paddr[2] != $past(paddr[2])) || (prdata[31:8] == '0 && prdata[7:0] == $past(pwdata[7:0])), "size register readback mismatch")

  // a waiting result stays put until taken
  `GBI_ASSERT(a_result_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(smoothed_value)), "waiting result changed")

endmodule

bind grid_bicubic_interpolator gbi_checker u_gbi_checker (.*);

// File: verif/tb_grid_bicubic_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_bicubic_interpolator
// Self-checking bench for the bicubic grid interpolator. Cell writes and
// fractional queries enter on the push side. A bit-exact model of the grid
// and of the cubic-convolution sum predicts every popped value. The run
// covers several grid sizes, random idle and stall patterns, and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_grid_bicubic_interpolator;
  import gbi_pkg::*;

  localparam int GRID_X       = MAX_CELLS_X_DEF;
  localparam int GRID_Y       = MAX_CELLS_Y_DEF;
  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int WSHIFT       = 3 * FRAC - 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int PRINT_LIMIT  = 20;

  typedef struct {
    logic                      func;
    logic [6:0]                wr_x;
    logic [6:0]                wr_y;
    logic [CELL_W-1:0]         wr_val;
    logic signed [QUERY_W-1:0] q_x;
    logic signed [QUERY_W-1:0] q_y;
  } grid_item_t;

  class interp_scoreboard;
    bit [CELL_W-1:0] cells [GRID_X*GRID_Y];
    int unsigned     limit_x;
    int unsigned     limit_y;
    bit [CELL_W-1:0] smoothed_q [$];
    int              errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      limit_x = CELLS_RESET;
      limit_y = CELLS_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic which, logic [CFG_W-1:0] val);
      if (which == REG_CELLS_X) begin
        limit_x = val;
      end else begin
        limit_y = val;
      end
    endfunction

    function int pending();
      return smoothed_q.size();
    endfunction

    // zero acts as one cell, oversize as the full store
    function int unsigned used_cells(int unsigned reg_val, int unsigned max_val);
      if (reg_val == 0) return 1;
      return (reg_val > max_val) ? max_val : reg_val;
    endfunction

    // round half up from Q.(3*FRAC) to Q.16
    function longint to_q16(longint w);
      return (w + (longint'(1) <<< (WSHIFT - 1))) >>> WSHIFT;
    endfunction

    // floor of the coordinate, plus its four kernel taps in Q.16
    function int kernel_taps(logic signed [QUERY_W-1:0] coord, output longint w [4]);
      longint s, t, u;
      s = longint'(1) <<< FRAC;
      t = longint'(coord[FRAC-1:0]);
      u = s - t;
      w[0] = to_q16(-t * u * u);
      w[1] = to_q16(t * t * t - 2 * t * t * s + s * s * s);
      w[2] = to_q16(u * u * u - 2 * u * u * s + s * s * s);
      w[3] = to_q16(-u * t * t);
      return int'(coord >>> FRAC);
    endfunction

    function int unsigned clamp_index(int idx, int unsigned n);
      if (idx < 0) return 0;
      if (idx >= int'(n)) return n - 1;
      return idx;
    endfunction

    function void note_input(grid_item_t it);
      longint      wx [4];
      longint      wy [4];
      int          bx, by, i, j;
      int unsigned nx, ny, cx, cy;
      longint      acc;
      longint      rounded;
      if (it.func == FUNC_WRITE) begin
        if (int'(it.wr_x) < GRID_X && int'(it.wr_y) < GRID_Y)
          cells[int'(it.wr_y) * GRID_X + int'(it.wr_x)] = it.wr_val;
        return;
      end
      nx = used_cells(limit_x, GRID_X);
      ny = used_cells(limit_y, GRID_Y);
      bx = kernel_taps(it.q_x, wx);
      by = kernel_taps(it.q_y, wy);
      acc = 0;
      for (i = 0; i < 4; i++) begin
        cx = clamp_index(bx - 1 + i, nx);
        for (j = 0; j < 4; j++) begin
          cy = clamp_index(by - 1 + j, ny);
          acc += wx[i] * wy[j] * longint'(cells[cy * GRID_X + cx]);
        end
      end
      if (acc < 0) begin
        rounded = 0;
      end else begin
        rounded = (acc + (longint'(1) <<< 31)) >>> 32;
        if (rounded > 65535) rounded = 65535;
      end
      smoothed_q.push_back(rounded[CELL_W-1:0]);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [CELL_W-1:0] got);
      bit [CELL_W-1:0] want;
      if (smoothed_q.size() == 0) begin
        report_mismatch($sformatf("smoothed_value %0h with no query pending", got));
        return;
      end
      want = smoothed_q.pop_front();
      if (got !== want)
        report_mismatch($sformatf("smoothed_value %0h, predicted %0h", got, want));
    endtask
  endclass

  logic                      clk, rst;
  logic                      push, full, func, empty, pop;
  logic [6:0]                write_x, write_y;
  logic [CELL_W-1:0]         write_value, smoothed_value;
  logic signed [QUERY_W-1:0] query_x, query_y;
  logic                      psel, penable, pwrite, pready;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata, prdata;

  interp_scoreboard sb;
  grid_item_t       seen_item;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               pop_hold = 0;
  longint           cycles = 0;

  grid_bicubic_interpolator dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (!rst) begin
      if (push && !full) begin
        seen_item.func   = func;
        seen_item.wr_x   = write_x;
        seen_item.wr_y   = write_y;
        seen_item.wr_val = write_value;
        seen_item.q_x    = query_x;
        seen_item.q_y    = query_y;
        sb.note_input(seen_item);
      end
      if (pop && !empty) sb.check_result(smoothed_value);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_item(grid_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push        <= 1'b1;
    func        <= it.func;
    write_x     <= it.wr_x;
    write_y     <= it.wr_y;
    write_value <= it.wr_val;
    query_x     <= it.q_x;
    query_y     <= it.q_y;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_write(int x, int y, int val);
    grid_item_t it;
    it.func = FUNC_WRITE;
    it.wr_x = 7'(x);
    it.wr_y = 7'(y);
    it.wr_val = CELL_W'(val);
    it.q_x = '0;
    it.q_y = '0;
    push_item(it);
  endtask

  task automatic send_query(int qx, int qy);
    grid_item_t it;
    it.func = FUNC_QUERY;
    it.wr_x = '0;
    it.wr_y = '0;
    it.wr_val = '0;
    it.q_x = QUERY_W'(qx);
    it.q_y = QUERY_W'(qy);
    push_item(it);
  endtask

  task automatic write_register(logic which, logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= APB_DW'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_limit(which, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sizes change only once every query has come out and writes have landed
  task automatic set_grid_size(logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    write_register(REG_CELLS_X, cx);
    @(negedge clk);
    write_register(REG_CELLS_Y, cy);
  endtask

  function automatic grid_item_t random_item(int base_x, int base_y);
    grid_item_t it;
    int roll;
    it.func   = ($urandom_range(99) < 45) ? FUNC_WRITE : FUNC_QUERY;
    it.wr_x   = 7'($urandom);
    it.wr_y   = 7'($urandom);
    it.wr_val = CELL_W'($urandom);
    it.q_x    = QUERY_W'($urandom);
    it.q_y    = QUERY_W'($urandom);
    roll = $urandom_range(99);
    if (it.func == FUNC_WRITE) begin
      // keep most writes inside the window the queries look at
      if (roll < 85) begin
        it.wr_x = 7'(base_x + int'($urandom_range(11)));
        it.wr_y = 7'(base_y + int'($urandom_range(11)));
      end
      roll = $urandom_range(99);
      if (roll < 8) it.wr_val = '0;
      else if (roll < 16) it.wr_val = '1;
      else if (roll < 45) it.wr_val = CELL_W'($urandom_range(65535, 58000));
    end else if (roll < 75) begin
      it.q_x = QUERY_W'((base_x - 2) * (1 << FRAC) + int'($urandom_range(16 << FRAC)));
      it.q_y = QUERY_W'((base_y - 2) * (1 << FRAC) + int'($urandom_range(16 << FRAC)));
    end else if (roll < 90) begin
      // straddle the far edge of the grid in use
      it.q_x = QUERY_W'((int'(sb.limit_x) - 3 + int'($urandom_range(5))) * (1 << FRAC)
               + int'($urandom_range((1 << FRAC) - 1)));
      it.q_y = QUERY_W'((int'(sb.limit_y) - 3 + int'($urandom_range(5))) * (1 << FRAC)
               + int'($urandom_range((1 << FRAC) - 1)));
    end
    return it;
  endfunction

  task automatic run_phase(int cx, int cy, int idle, int stall, int hold, int count);
    int base_x, base_y, k;
    set_grid_size(CFG_W'(cx), CFG_W'(cy));
    send_idle_pct = idle;
    stall_pct = stall;
    pop_hold = hold;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        base_x = int'($urandom_range((cx > 116) ? 116 : cx));
        base_y = int'($urandom_range((cy > 116) ? 116 : cy));
      end
      push_item(random_item(base_x, base_y));
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    func = FUNC_WRITE;
    write_x = '0;
    write_y = '0;
    write_value = '0;
    query_x = '0;
    query_y = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corner cells, a saturating block near the origin, mixed values elsewhere
    send_write(0, 0, 16'hffff);
    send_write(1, 0, 16'hffff);
    send_write(0, 1, 16'hffff);
    send_write(1, 1, 16'hffff);
    send_write(2, 1, 16'hffff);
    send_write(1, 2, 16'hffff);
    send_write(127, 127, 16'hffff);
    send_write(127, 126, 16'h0001);
    send_write(126, 127, 16'h8000);
    send_write(64, 64, 16'h1234);
    send_write(65, 64, 16'h0000);
    send_query(0, 0);
    send_query(128, 128);
    send_query(255, 255);
    send_query(-65536, -65536);
    send_query(65535, 65535);
    send_query(127 * 256, 127 * 256);
    send_query(-1, -1);
    send_query(64 * 256 + 128, 64 * 256 + 1);
    send_query(256, 255);
    send_query(126 * 256 + 200, 127 * 256);
    send_query(40 * 256, 20 * 256);

    run_phase(128, 128, 0, 0, 0, 250);
    run_phase(0, 255, 72, 0, 0, 250);
    run_phase(255, 0, 0, 72, 0, 250);
    run_phase(1, 1, 14, 14, 0, 150);
    run_phase(16, 9, 0, 0, 600, 200);
    run_phase(int'($urandom_range(127, 2)), int'($urandom_range(127, 2)), 14, 14, 0, 250);
    run_phase(128, 3, 72, 0, 0, 250);
    run_phase(int'($urandom_range(255)), int'($urandom_range(255)), 0, 72, 0, 200);

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/gbi_pkg.sv
design/gbi_ram.sv
design/gbi_fifo.sv
design/gbi_weight.sv
design/gbi_front.sv
design/gbi_back.sv
design/grid_bicubic_interpolator.sv
design/gbi_checker.sv
verif/tb_grid_bicubic_interpolator.sv
